// ----- rtl/core/tracking_flight_mode_sequencer_defines.svh -----
// Assertion macros for the flight mode sequencer.
// Included by the top level; the including scope must have clk and arst_n.
`ifndef TRACKING_FLIGHT_MODE_SEQUENCER_DEFINES_SVH
`define TRACKING_FLIGHT_MODE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define TFMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TFMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tfms_pkg.sv -----
// Shared types, codes and helpers for the flight mode sequencer.
// No dependencies; used by tfms_travel and the top level.
package tfms_pkg;

	// position width and derived datapath widths
	localparam int unsigned POS_BITS   = 16;
	localparam int unsigned DIFF_BITS  = ((POS_BITS > 16) ? POS_BITS : 16) + 1;
	localparam int unsigned MAG_BITS   = DIFF_BITS;
	localparam int unsigned EFF_BITS   = (MAG_BITS > 22) ? 22 : MAG_BITS;
	localparam int unsigned SCL_BITS   = EFF_BITS + 10;
	localparam int unsigned ROOT_BITS  = SCL_BITS + 1;
	localparam int unsigned SUM_BITS   = 2 * ROOT_BITS;
	localparam int unsigned CNT_BITS   = $clog2(ROOT_BITS);
	localparam int unsigned LIM_BITS   = (MAG_BITS > 23) ? MAG_BITS : 23;
	localparam int unsigned MAG_LIMIT  = 2 ** 21;
	localparam int unsigned SCALE      = 1000;
	localparam int unsigned ADDR_BITS  = 5;

	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_JOY    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_WAYPT   = 2'd1;
	localparam logic [1:0] CMD_SETPT   = 2'd2;

	localparam logic [2:0] REG_MAX_SPEED = 3'd0;
	localparam logic [2:0] REG_FENCE_X   = 3'd1;
	localparam logic [2:0] REG_FENCE_Y   = 3'd2;
	localparam logic [2:0] REG_HOVER_Z   = 3'd3;
	localparam logic [2:0] REG_MIN_TRAV  = 3'd4;
	localparam logic [2:0] REG_MAX_TRAV  = 3'd5;
	localparam logic [2:0] REG_TOUCHDOWN = 3'd6;

	localparam logic [13:0] RST_MAX_SPEED = 14'd400;
	localparam logic [14:0] RST_FENCE_X   = 15'd1000;
	localparam logic [14:0] RST_FENCE_Y   = 15'd1500;
	localparam logic [14:0] RST_HOVER_Z   = 15'd1000;
	localparam logic [15:0] RST_MIN_TRAV  = 16'd1000;
	localparam logic [15:0] RST_MAX_TRAV  = 16'd10000;
	localparam logic [15:0] RST_TOUCHDOWN = 16'd3000;

	typedef enum logic [1:0] {MODE_IDLE, MODE_TAKEOFF, MODE_HOVER, MODE_TRACK} mode_t;
	typedef enum logic [1:0] {PLAN_NONE, PLAN_SETPT, PLAN_WAYPT, PLAN_LAND} plan_t;
	typedef enum logic [1:0] {SEQ_IDLE, SEQ_CALC, SEQ_EMIT} seq_state_t;
	typedef enum logic [2:0] {TRV_IDLE, TRV_SQ, TRV_SQRT, TRV_DIV, TRV_DONE} trv_state_t;

	typedef struct packed {
		logic [1:0]                 kind;
		logic                       button_toggle;
		logic                       button_start;
		logic                       done_in;
		logic signed [POS_BITS-1:0] drone_x;
		logic signed [POS_BITS-1:0] drone_y;
		logic signed [POS_BITS-1:0] drone_z;
		logic signed [POS_BITS-1:0] rover_x;
		logic signed [POS_BITS-1:0] rover_y;
		logic signed [15:0]         rover_vx;
		logic signed [15:0]         rover_vy;
	} evt_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic signed [POS_BITS-1:0] target_x;
		logic signed [POS_BITS-1:0] target_y;
		logic signed [POS_BITS-1:0] target_z;
		logic signed [15:0]         vel_x;
		logic signed [15:0]         vel_y;
		logic [15:0]                travel_time;
		logic                       out_of_fence;
		logic                       last;
	} rslt_t;

	typedef struct packed {
		logic [13:0] max_speed;
		logic [14:0] fence_x_limit;
		logic [14:0] fence_y_limit;
		logic [14:0] hover_height;
		logic [15:0] min_travel_ms;
		logic [15:0] max_travel_ms;
		logic [15:0] touchdown_ms;
	} cfg_regs_t;

	// travel-time request: three signed distance components
	typedef struct packed {
		logic                       start;
		logic [2:0][DIFF_BITS-1:0]  d;
	} trv_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [15:0] travel_time;
	} trv_rsp_t;

	function automatic logic signed [DIFF_BITS-1:0] sx_pos(input logic signed [POS_BITS-1:0] p);
		return DIFF_BITS'(p);
	endfunction

	function automatic logic signed [DIFF_BITS-1:0] ext_u15(input logic [14:0] l);
		return $signed(DIFF_BITS'(l));
	endfunction

	function automatic logic outside(input logic signed [POS_BITS-1:0] p,
			input logic [14:0] l);
		logic signed [DIFF_BITS-1:0] pv;
		logic signed [DIFF_BITS-1:0] lv;
		pv = sx_pos(p);
		lv = ext_u15(l);
		return (pv > lv) || (pv < -lv);
	endfunction

	function automatic logic signed [POS_BITS-1:0] clamp_sym(
			input logic signed [POS_BITS-1:0] p, input logic [14:0] l);
		logic signed [DIFF_BITS-1:0] pv;
		logic signed [DIFF_BITS-1:0] lv;
		pv = sx_pos(p);
		lv = ext_u15(l);
		if (pv > lv) return POS_BITS'(lv);
		else if (pv < -lv) return POS_BITS'(-lv);
		else return p;
	endfunction

endpackage

// ----- rtl/core/tracking_flight_mode_sequencer.sv -----
// Top level of the flight mode sequencer: APB registers, mode/flag state,
// result buffering. Depends on tfms_pkg, tfms_travel and the defines header.
//
// Usage:
//   evt channel (valid/ready) carries one word per event: control tick,
//   joystick event or status event. rslt channel (valid/ready) returns the
//   result words of a tick: one, or two for the landing sequence (last marks
//   the final word). Events produce no result words.
//   An event is taken while the sequencer is idle. A tick without a waypoint
//   passes through the emit state into the output register; no new event is
//   taken until its last word is loaded. A tick that sends a waypoint runs the
//   travel-time unit (serial squaring, square root, then division; skipped
//   when a distance is out of range or max speed is zero) before the first
//   result word; that serial datapath limits how often such ticks are taken.
//   The result sits in an output register; once the last word is loaded the
//   block takes the next event even if that word is not yet taken.
//   A stalled receiver holds the result words and, for a landing pair, the
//   second word waits inside until the first is taken.
//   Reset (arst_n low) returns mode to idle, flags to flying=0, tracking=0,
//   done=1, and registers to their defaults. pready is tied high.
`include "tracking_flight_mode_sequencer_defines.svh"

module tracking_flight_mode_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tfms_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  tfms_pkg::evt_t                    evt,
	output logic                              rslt_valid,
	input  logic                              rslt_ready,
	output tfms_pkg::rslt_t                   rslt
);

	localparam int unsigned PW = tfms_pkg::POS_BITS;
	localparam int unsigned DW = tfms_pkg::DIFF_BITS;

	tfms_pkg::cfg_regs_t  cfg_q;
	tfms_pkg::seq_state_t seq_q, seq_nxt;
	tfms_pkg::mode_t      mode_q, mode_nxt;
	logic                 flying_q, tracking_q, done_q, done_nxt;

	tfms_pkg::plan_t      plan_q, plan_nxt;
	logic                 idx_q;
	logic                 oof_q, oof_nxt;
	logic signed [PW-1:0] tx_q, ty_q, tx_nxt, ty_nxt;
	logic signed [15:0]   vx_q, vy_q, vx_nxt, vy_nxt;
	logic [15:0]          tt_q;
	logic                 need_trv;

	tfms_pkg::rslt_t      rslt_q, rslt_nxt;
	logic                 rslt_valid_q;
	logic                 rslt_load;
	logic                 evt_accept, tick_accept;
	logic                 cfg_wr;

	logic signed [PW-1:0] cx, cy;
	logic signed [DW-1:0] hz_s;
	logic signed [PW-1:0] hz_pos;

	tfms_pkg::trv_req_t   trv_req;
	tfms_pkg::trv_rsp_t   trv_rsp;
	logic [2:0][DW-1:0]   trv_d;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[tfms_pkg::ADDR_BITS-1:2])
			tfms_pkg::REG_MAX_SPEED: prdata = 32'(cfg_q.max_speed);
			tfms_pkg::REG_FENCE_X:   prdata = 32'(cfg_q.fence_x_limit);
			tfms_pkg::REG_FENCE_Y:   prdata = 32'(cfg_q.fence_y_limit);
			tfms_pkg::REG_HOVER_Z:   prdata = 32'(cfg_q.hover_height);
			tfms_pkg::REG_MIN_TRAV:  prdata = 32'(cfg_q.min_travel_ms);
			tfms_pkg::REG_MAX_TRAV:  prdata = 32'(cfg_q.max_travel_ms);
			tfms_pkg::REG_TOUCHDOWN: prdata = 32'(cfg_q.touchdown_ms);
			default:                 prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed     <= tfms_pkg::RST_MAX_SPEED;
			cfg_q.fence_x_limit <= tfms_pkg::RST_FENCE_X;
			cfg_q.fence_y_limit <= tfms_pkg::RST_FENCE_Y;
			cfg_q.hover_height  <= tfms_pkg::RST_HOVER_Z;
			cfg_q.min_travel_ms <= tfms_pkg::RST_MIN_TRAV;
			cfg_q.max_travel_ms <= tfms_pkg::RST_MAX_TRAV;
			cfg_q.touchdown_ms  <= tfms_pkg::RST_TOUCHDOWN;
		end else if (cfg_wr) begin
			case (paddr[tfms_pkg::ADDR_BITS-1:2])
				tfms_pkg::REG_MAX_SPEED: cfg_q.max_speed     <= pwdata[13:0];
				tfms_pkg::REG_FENCE_X:   cfg_q.fence_x_limit <= pwdata[14:0];
				tfms_pkg::REG_FENCE_Y:   cfg_q.fence_y_limit <= pwdata[14:0];
				tfms_pkg::REG_HOVER_Z:   cfg_q.hover_height  <= pwdata[14:0];
				tfms_pkg::REG_MIN_TRAV:  cfg_q.min_travel_ms <= pwdata[15:0];
				tfms_pkg::REG_MAX_TRAV:  cfg_q.max_travel_ms <= pwdata[15:0];
				tfms_pkg::REG_TOUCHDOWN: cfg_q.touchdown_ms  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- tick decision ----------------
	assign cx     = tfms_pkg::clamp_sym(evt.rover_x, cfg_q.fence_x_limit);
	assign cy     = tfms_pkg::clamp_sym(evt.rover_y, cfg_q.fence_y_limit);
	assign hz_s   = tfms_pkg::ext_u15(cfg_q.hover_height);
	assign hz_pos = PW'(cfg_q.hover_height);

	always_comb begin
		mode_nxt  = mode_q;
		done_nxt  = done_q;
		plan_nxt  = tfms_pkg::PLAN_NONE;
		tx_nxt    = '0;
		ty_nxt    = '0;
		vx_nxt    = '0;
		vy_nxt    = '0;
		need_trv  = 1'b0;
		trv_d     = '0;
		oof_nxt   = tfms_pkg::outside(evt.drone_x, cfg_q.fence_x_limit) ||
		            tfms_pkg::outside(evt.drone_y, cfg_q.fence_y_limit);
		case (mode_q)
			tfms_pkg::MODE_IDLE: begin
				if (flying_q && done_q) mode_nxt = tfms_pkg::MODE_TAKEOFF;
			end
			tfms_pkg::MODE_TAKEOFF: begin
				if (done_q) begin
					plan_nxt = tfms_pkg::PLAN_WAYPT;
					need_trv = 1'b1;
					done_nxt = 1'b0;
					mode_nxt = tfms_pkg::MODE_HOVER;
					trv_d[0] = tfms_pkg::sx_pos(evt.drone_x);
					trv_d[1] = tfms_pkg::sx_pos(evt.drone_y);
					trv_d[2] = hz_s - tfms_pkg::sx_pos(evt.drone_z);
				end
			end
			tfms_pkg::MODE_HOVER: begin
				if (done_q && !flying_q) begin
					plan_nxt = tfms_pkg::PLAN_LAND;
					need_trv = 1'b1;
					done_nxt = 1'b0;
					mode_nxt = tfms_pkg::MODE_IDLE;
					trv_d[0] = tfms_pkg::sx_pos(evt.drone_x);
					trv_d[1] = tfms_pkg::sx_pos(evt.drone_y);
					trv_d[2] = tfms_pkg::sx_pos(evt.drone_z);
				end else if (tracking_q && done_q) begin
					plan_nxt = tfms_pkg::PLAN_WAYPT;
					need_trv = 1'b1;
					done_nxt = 1'b0;
					mode_nxt = tfms_pkg::MODE_TRACK;
					tx_nxt   = cx;
					ty_nxt   = cy;
					trv_d[0] = tfms_pkg::sx_pos(cx) - tfms_pkg::sx_pos(evt.drone_x);
					trv_d[1] = tfms_pkg::sx_pos(cy) - tfms_pkg::sx_pos(evt.drone_y);
				end
			end
			tfms_pkg::MODE_TRACK: begin
				if (done_q) begin
					plan_nxt = tfms_pkg::PLAN_SETPT;
					tx_nxt   = cx;
					ty_nxt   = cy;
					vx_nxt   = tfms_pkg::outside(evt.rover_x, cfg_q.fence_x_limit) ?
					           16'sd0 : evt.rover_vx;
					vy_nxt   = tfms_pkg::outside(evt.rover_y, cfg_q.fence_y_limit) ?
					           16'sd0 : evt.rover_vy;
				end
				if (!tracking_q) mode_nxt = tfms_pkg::MODE_HOVER;
			end
			default: begin
			end
		endcase
	end

	// ---------------- sequencer control ----------------
	always_comb begin
		seq_nxt = seq_q;
		case (seq_q)
			tfms_pkg::SEQ_IDLE: begin
				if (evt_valid && (evt.kind == tfms_pkg::KIND_TICK))
					seq_nxt = need_trv ? tfms_pkg::SEQ_CALC : tfms_pkg::SEQ_EMIT;
			end
			tfms_pkg::SEQ_CALC: begin
				if (trv_rsp.done) seq_nxt = tfms_pkg::SEQ_EMIT;
			end
			tfms_pkg::SEQ_EMIT: begin
				if (rslt_load && rslt_nxt.last) seq_nxt = tfms_pkg::SEQ_IDLE;
			end
			default: seq_nxt = tfms_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		evt_ready     = (seq_q == tfms_pkg::SEQ_IDLE);
		evt_accept    = evt_valid && evt_ready;
		tick_accept   = evt_accept && (evt.kind == tfms_pkg::KIND_TICK);
		rslt_load     = (seq_q == tfms_pkg::SEQ_EMIT) && (!rslt_valid_q || rslt_ready);
		trv_req.start = tick_accept && need_trv;
		trv_req.d     = trv_d;
	end

	// result word for the current plan and word index
	always_comb begin
		rslt_nxt              = '0;
		rslt_nxt.out_of_fence = oof_q;
		rslt_nxt.last         = 1'b1;
		case (plan_q)
			tfms_pkg::PLAN_SETPT: begin
				rslt_nxt.command  = tfms_pkg::CMD_SETPT;
				rslt_nxt.target_x = tx_q;
				rslt_nxt.target_y = ty_q;
				rslt_nxt.target_z = hz_pos;
				rslt_nxt.vel_x    = vx_q;
				rslt_nxt.vel_y    = vy_q;
			end
			tfms_pkg::PLAN_WAYPT: begin
				rslt_nxt.command     = tfms_pkg::CMD_WAYPT;
				rslt_nxt.target_x    = tx_q;
				rslt_nxt.target_y    = ty_q;
				rslt_nxt.target_z    = hz_pos;
				rslt_nxt.travel_time = tt_q;
			end
			tfms_pkg::PLAN_LAND: begin
				// climb-to-hover word first, then touchdown at ground level
				rslt_nxt.command     = tfms_pkg::CMD_WAYPT;
				rslt_nxt.target_z    = idx_q ? '0 : hz_pos;
				rslt_nxt.travel_time = idx_q ? cfg_q.touchdown_ms : tt_q;
				rslt_nxt.last        = idx_q;
			end
			default: begin
				rslt_nxt.command = tfms_pkg::CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= tfms_pkg::SEQ_IDLE;
			mode_q       <= tfms_pkg::MODE_IDLE;
			flying_q     <= 1'b0;
			tracking_q   <= 1'b0;
			done_q       <= 1'b1;
			plan_q       <= tfms_pkg::PLAN_NONE;
			idx_q        <= 1'b0;
			rslt_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_nxt;
			if (evt_accept) begin
				case (evt.kind)
					tfms_pkg::KIND_TICK: begin
						mode_q <= mode_nxt;
						done_q <= done_nxt;
						plan_q <= plan_nxt;
					end
					tfms_pkg::KIND_JOY: begin
						if (evt.button_toggle && flying_q) tracking_q <= !tracking_q;
						else if (evt.button_start && (mode_q == tfms_pkg::MODE_IDLE))
							flying_q <= 1'b1;
						else if (evt.button_start && (mode_q == tfms_pkg::MODE_HOVER))
							flying_q <= 1'b0;
					end
					tfms_pkg::KIND_STATUS: done_q <= evt.done_in;
					default: begin
					end
				endcase
			end
			if (rslt_load) begin
				idx_q        <= !rslt_nxt.last;
				rslt_valid_q <= 1'b1;
			end else if (rslt_ready) begin
				rslt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_accept) begin
			oof_q <= oof_nxt;
			tx_q  <= tx_nxt;
			ty_q  <= ty_nxt;
			vx_q  <= vx_nxt;
			vy_q  <= vy_nxt;
		end
		if (trv_rsp.done) tt_q <= trv_rsp.travel_time;
		if (rslt_load) rslt_q <= rslt_nxt;
	end

	assign rslt_valid = rslt_valid_q;
	assign rslt       = rslt_q;

	tfms_travel u_travel (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (trv_req),
		.rsp    (trv_rsp)
	);

	// ---------------- assertions ----------------
	`TFMS_ASSERT_NOW(a_ready_trv_idle, evt_ready, !trv_rsp.busy, "event taken while travel unit busy")
	`TFMS_ASSERT_NOW(a_done_in_calc, trv_rsp.done, seq_q == tfms_pkg::SEQ_CALC, "travel result outside calc")
	`TFMS_ASSERT_NOW(a_pair_held, rslt_valid_q && !rslt_q.last, seq_q == tfms_pkg::SEQ_EMIT, "second landing word lost")
	`TFMS_ASSERT_NEXT(a_start_busy, trv_req.start, trv_rsp.busy, "travel unit ignored start")

endmodule

// ----- rtl/core/tfms_travel.sv -----
// Waypoint travel-time unit: bit-serial sum of squares, digit-serial square root,
// bit-serial divide by max speed, then clamp. Depends on tfms_pkg.
module tfms_travel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfms_pkg::cfg_regs_t  cfg,
	input  tfms_pkg::trv_req_t   req,
	output tfms_pkg::trv_rsp_t   rsp
);

	localparam int unsigned DW   = tfms_pkg::DIFF_BITS;
	localparam int unsigned EW   = tfms_pkg::EFF_BITS;
	localparam int unsigned SW   = tfms_pkg::SCL_BITS;
	localparam int unsigned RW   = tfms_pkg::ROOT_BITS;
	localparam int unsigned UW   = tfms_pkg::SUM_BITS;
	localparam int unsigned CW   = tfms_pkg::CNT_BITS;
	localparam int unsigned LW   = tfms_pkg::LIM_BITS;

	function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
		return v[DW-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

	tfms_pkg::trv_state_t state_q, state_nxt;

	logic [UW-1:0] mc_q [3];
	logic [SW-1:0] mp_q [3];
	logic [UW-1:0] acc_q;
	logic [RW:0]   rem_q;
	logic [RW-1:0] root_q;
	logic [13:0]   drem_q;
	logic [CW-1:0] cnt_q;
	logic          over_q;

	logic [DW-1:0] mag  [3];
	logic [SW-1:0] scl  [3];
	logic          over_start;
	logic [UW-1:0] pp_sum;
	logic [RW+1:0] sq_r2, sq_trial;
	logic          sq_ge;
	logic [RW:0]   rem_nxt;
	logic [14:0]   dv_t;
	logic          dv_ge;
	logic [13:0]   drem_nxt;
	logic [15:0]   tt_clamp;
	logic          cnt_zero;

	// start: magnitudes, range check, scale by 1000 so the root comes out in ms units
	always_comb begin
		over_start = (cfg.max_speed == 14'd0);
		for (int k = 0; k < 3; k++) begin
			mag[k] = mag_of(req.d[k]);
			scl[k] = SW'(mag[k][EW-1:0]) * SW'(tfms_pkg::SCALE);
			if (LW'(mag[k]) > LW'(tfms_pkg::MAG_LIMIT)) over_start = 1'b1;
		end
	end

	always_comb begin
		pp_sum = acc_q;
		for (int k = 0; k < 3; k++) begin
			if (mp_q[k][0]) pp_sum = pp_sum + mc_q[k];
		end
	end

	// one root bit per cycle, two radicand bits in
	assign sq_r2    = {rem_q[RW-1:0], acc_q[UW-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = (sq_r2 >= sq_trial);
	assign rem_nxt  = sq_ge ? (RW+1)'(sq_r2 - sq_trial) : (RW+1)'(sq_r2);

	// restoring divide, dividend shifts out of root_q while quotient shifts in
	assign dv_t     = {drem_q, root_q[RW-1]};
	assign dv_ge    = (dv_t >= {1'b0, cfg.max_speed});
	assign drem_nxt = dv_ge ? 14'(dv_t - {1'b0, cfg.max_speed}) : dv_t[13:0];

	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		if (over_q || (root_q > RW'(cfg.max_travel_ms))) tt_clamp = cfg.max_travel_ms;
		else if (root_q < RW'(cfg.min_travel_ms)) tt_clamp = cfg.min_travel_ms;
		else tt_clamp = root_q[15:0];
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tfms_pkg::TRV_IDLE: begin
				if (req.start) state_nxt = over_start ? tfms_pkg::TRV_DONE : tfms_pkg::TRV_SQ;
			end
			tfms_pkg::TRV_SQ: begin
				if (cnt_zero) state_nxt = tfms_pkg::TRV_SQRT;
			end
			tfms_pkg::TRV_SQRT: begin
				if (cnt_zero) state_nxt = tfms_pkg::TRV_DIV;
			end
			tfms_pkg::TRV_DIV: begin
				if (cnt_zero) state_nxt = tfms_pkg::TRV_DONE;
			end
			tfms_pkg::TRV_DONE: state_nxt = tfms_pkg::TRV_IDLE;
			default: state_nxt = tfms_pkg::TRV_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy        = (state_q != tfms_pkg::TRV_IDLE);
		rsp.done        = (state_q == tfms_pkg::TRV_DONE);
		rsp.travel_time = tt_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfms_pkg::TRV_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tfms_pkg::TRV_IDLE: begin
				if (req.start) begin
					for (int k = 0; k < 3; k++) begin
						mc_q[k] <= UW'(scl[k]);
						mp_q[k] <= scl[k];
					end
					acc_q  <= '0;
					over_q <= over_start;
					cnt_q  <= CW'(SW - 1);
				end
			end
			tfms_pkg::TRV_SQ: begin
				acc_q <= pp_sum;
				for (int k = 0; k < 3; k++) begin
					mc_q[k] <= mc_q[k] << 1;
					mp_q[k] <= mp_q[k] >> 1;
				end
				if (cnt_zero) begin
					cnt_q  <= CW'(RW - 1);
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			tfms_pkg::TRV_SQRT: begin
				acc_q  <= acc_q << 2;
				rem_q  <= rem_nxt;
				root_q <= {root_q[RW-2:0], sq_ge};
				if (cnt_zero) begin
					cnt_q  <= CW'(RW - 1);
					drem_q <= '0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			tfms_pkg::TRV_DIV: begin
				drem_q <= drem_nxt;
				root_q <= {root_q[RW-2:0], dv_ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
